[hw/rtl/wfba_pkg.sv]
// Shared constants and types for the worst-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

package wfba_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int ADDR_BITS  = $clog2(MAX_BLOCKS);
   localparam int COUNT_BITS = $clog2(MAX_BLOCKS + 1);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic                 clear;
      logic                 sample;
      logic [ADDR_BITS-1:0] index;
   } scan_ctl_type;

   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] best_index;
      logic [SIZE_BITS-1:0] best_size;
   } scan_res_type;

endpackage

`default_nettype wire

[hw/rtl/worst_fit_block_allocator.sv]
// Top level of the worst-fit block allocator: control, table RAM and result port.
//
// Usage: present an item on the req_ ports and raise start; it is taken at a
// rising edge where start is high and busy is low. A load item
// (req_operation = 0) writes one block's free size in the cycle it is taken
// and gives no result; busy stays low, so loads may follow every cycle.
// An allocate item reads the blocks in use from the table RAM, one per
// cycle, keeps the largest size that covers the request, then writes the
// reduced size back and presents one result on the rsp_ ports for exactly
// one cycle, marked by rsp_valid. The scan goes through ST_READ for N entries,
// N being block_count limited to 16, then ST_DRAIN and ST_FINISH, which
// writes back and loads the rsp_ registers; for N of zero it goes straight
// to ST_FINISH. The single RAM read port reads one entry per cycle.
// The next item may be taken in the cycle the result is shown.
// The receiver cannot stall: each result is taken in the cycle it is shown.
// block_count is written through csr_write_enable/csr_write_data while the
// block is idle, which is up to the user; the block does not enforce it. Reset
// clears control state and block_count; entries stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module worst_fit_block_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic [3:0]                     req_block_index,
   input  wire logic [15:0]                    req_size_value,
   input  wire logic                           req_last_request,
   output logic                                rsp_valid,
   output logic                                rsp_granted,
   output logic [3:0]                          rsp_chosen_block,
   output logic [15:0]                         rsp_size_left,
   output logic                                rsp_batch_done,
   input  wire logic                           csr_write_enable,
   input  wire logic [4:0]                     csr_write_data
);
   import wfba_pkg::*;

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] used_ff, used_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic                  rd_valid_ff;
   logic [ADDR_BITS-1:0]  rd_index_ff;
   logic [SIZE_BITS-1:0]  request_ff, request_in;
   logic                  last_ff, last_in;

   logic                  rsp_valid_ff;
   logic                  rsp_granted_ff;
   logic [3:0]            rsp_chosen_ff;
   logic [15:0]           rsp_left_ff;
   logic                  rsp_done_ff;

   logic                  accept;
   logic                  is_alloc;
   logic [COUNT_BITS-1:0] used_sat;
   logic                  last_addr;
   logic [SIZE_BITS-1:0]  remainder;

   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [SIZE_BITS-1:0]  wr_data;
   logic [SIZE_BITS-1:0]  rd_data;

   scan_ctl_type          scan_ctl;
   scan_res_type          scan_res;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign is_alloc = (req_operation == OP_ALLOC);

   assign used_sat  = (count_ff > COUNT_BITS'(MAX_BLOCKS)) ? COUNT_BITS'(MAX_BLOCKS)
                                                           : count_ff;
   assign last_addr = ({1'b0, addr_ff} == (used_ff - COUNT_BITS'(1)));
   assign remainder = scan_res.best_size - request_ff;

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      addr_in    = addr_ff;
      request_in = request_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_alloc) begin
               used_in    = used_sat;
               addr_in    = '0;
               request_in = req_size_value[SIZE_BITS-1:0];
               last_in    = req_last_request;
               state_in   = (used_sat == '0) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            addr_in = addr_ff + ADDR_BITS'(1);
            if (last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            count_ff <= csr_write_data[COUNT_BITS-1:0];
         end
         rd_valid_ff  <= (state_ff == ST_READ);
         rsp_valid_ff <= (state_ff == ST_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      used_ff     <= used_in;
      addr_ff     <= addr_in;
      request_ff  <= request_in;
      last_ff     <= last_in;
      rd_index_ff <= addr_ff;
      if (state_ff == ST_FINISH) begin
         rsp_granted_ff <= scan_res.found;
         rsp_chosen_ff  <= scan_res.found ? 4'(scan_res.best_index) : 4'd0;
         rsp_left_ff    <= scan_res.found ? 16'(remainder) : 16'd0;
         rsp_done_ff    <= last_ff;
      end
   end

   // Loads write in the cycle they are taken; the write-back of a grant is the
   // only other write and happens while no read is in flight.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_res.best_index;
      wr_data = remainder;
      if (accept && !is_alloc) begin
         wr_en   = (COUNT_BITS'(req_block_index) < COUNT_BITS'(MAX_BLOCKS));
         wr_addr = ADDR_BITS'(req_block_index);
         wr_data = req_size_value[SIZE_BITS-1:0];
      end else if (state_ff == ST_FINISH) begin
         wr_en = scan_res.found;
      end
   end

   wfba_ram #(
      .WIDTH(SIZE_BITS),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign scan_ctl.clear  = accept;
   assign scan_ctl.sample = rd_valid_ff;
   assign scan_ctl.index  = rd_index_ff;

   wfba_scan u_scan (
      .clock  (clock),
      .ctl    (scan_ctl),
      .rd_data(rd_data),
      .request(request_ff),
      .res    (scan_res)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_size_left    = rsp_left_ff;
   assign rsp_batch_done   = rsp_done_ff;

   // Results never come in two consecutive cycles.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe high in two consecutive cycles");

   // An allocate item always occupies the block after it is taken.
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && is_alloc) |=> busy)
      else $error("allocate item taken without going busy");

   // Outside idle the table is written only by the write-back of a grant.
   a_write_only_on_grant: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff != ST_IDLE)) |-> ((state_ff == ST_FINISH) && scan_res.found))
      else $error("table written during a scan");

   // The grant flag follows the found flag of the scan.
   a_grant_from_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (rsp_granted_ff == $past(scan_res.found)))
      else $error("grant flag does not follow the scan");

endmodule

`default_nettype wire

[hw/rtl/wfba_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wfba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/wfba_scan.sv]
// Running search for the largest stored size that covers the request.
`timescale 1ns / 1ps
`default_nettype none

module wfba_scan (
   input  wire logic                          clock,
   input  wire wfba_pkg::scan_ctl_type        ctl,
   input  wire logic [wfba_pkg::SIZE_BITS-1:0] rd_data,
   input  wire logic [wfba_pkg::SIZE_BITS-1:0] request,
   output wfba_pkg::scan_res_type             res
);
   import wfba_pkg::*;

   logic                 found_ff, found_in;
   logic [ADDR_BITS-1:0] best_index_ff, best_index_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;
   logic                 take;

   // A strictly larger size is needed to displace the current best, so the
   // lowest index wins on a tie.
   assign take = ctl.sample && (rd_data >= request) &&
                 (!found_ff || (best_size_ff < rd_data));

   always_comb begin
      found_in      = found_ff;
      best_index_in = best_index_ff;
      best_size_in  = best_size_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in      = 1'b1;
         best_index_in = ctl.index;
         best_size_in  = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      found_ff      <= found_in;
      best_index_ff <= best_index_in;
      best_size_ff  <= best_size_in;
   end

   assign res.found      = found_ff;
   assign res.best_index = best_index_ff;
   assign res.best_size  = best_size_ff;

endmodule

`default_nettype wire
